/* src/rbd_pkg.sv */
// Shared constants, command and status codes, and cell control type for the deque core
package rbd_pkg;

  localparam int DEPTH  = 16;
  localparam int WORD_W = 32;
  localparam int CNT_W  = 5;
  localparam int CAP_W  = 5;

  typedef enum logic [1:0] {
    CMD_ENQ       = 2'd0,
    CMD_DEQ_FRONT = 2'd1,
    CMD_DEQ_REAR  = 2'd2,
    CMD_STATUS    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // one-cycle control broadcast to every cell
  typedef struct packed {
    logic flush;
    logic enq;
    logic deq_front;
    logic deq_rear;
  } cell_ctrl_t;

endpackage

/* src/rbd_ifs.sv */
// Request, result and configuration channel interfaces
interface rbd_in_if;
  logic                                valid;
  logic                                ready;
  logic [1:0]                          cmd;
  logic signed [rbd_pkg::WORD_W-1:0]   data_in;
  modport source (output valid, cmd, data_in, input ready);
  modport sink   (input valid, cmd, data_in, output ready);
endinterface

interface rbd_out_if;
  logic                                valid;
  logic                                ready;
  logic [1:0]                          status;
  logic signed [rbd_pkg::WORD_W-1:0]   data_out;
  logic signed [rbd_pkg::WORD_W-1:0]   front_word;
  logic signed [rbd_pkg::WORD_W-1:0]   rear_word;
  logic [rbd_pkg::CNT_W-1:0]           occupancy;
  logic                                is_full;
  logic                                is_empty;
  modport source (output valid, status, data_out, front_word, rear_word, occupancy,
                  is_full, is_empty, input ready);
  modport sink   (input valid, status, data_out, front_word, rear_word, occupancy,
                  is_full, is_empty, output ready);
endinterface

interface rbd_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [rbd_pkg::CAP_W-1:0]  capacity_in_use;
  modport source (output valid, capacity_in_use, input ready);
  modport sink   (input valid, capacity_in_use, output ready);
endinterface

/* src/rbd_cell.sv */
// One storage cell of the deque chain: shifts toward the front, fills and clears at the rear
module rbd_cell (
  input  logic                               clk,
  input  logic                               rst_n,
  input  rbd_pkg::cell_ctrl_t                ctrl,
  input  logic signed [rbd_pkg::WORD_W-1:0]  data_in,
  input  logic                               prev_valid,
  input  logic                               next_valid,
  input  logic signed [rbd_pkg::WORD_W-1:0]  next_data,
  output logic                               valid,
  output logic signed [rbd_pkg::WORD_W-1:0]  data,
  output logic                               is_rear
);

  logic                              valid_r, valid_nxt;
  logic signed [rbd_pkg::WORD_W-1:0] data_r, data_nxt;

  assign is_rear = valid_r & ~next_valid;

  always_comb begin
    valid_nxt = valid_r;
    data_nxt  = data_r;
    if (ctrl.flush) begin
      valid_nxt = 1'b0;
    end else if (ctrl.enq) begin
      // first empty slot behind the occupied run takes the word
      if (prev_valid && !valid_r) begin
        valid_nxt = 1'b1;
        data_nxt  = data_in;
      end
    end else if (ctrl.deq_front) begin
      valid_nxt = next_valid;
      data_nxt  = next_data;
    end else if (ctrl.deq_rear) begin
      if (is_rear) valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign valid = valid_r;
  assign data  = data_r;

endmodule

/* src/ring_buffer_deque_core.sv */
// Top level of the double-ended buffer: command decode, cell chain and result registers
//
//  channel | dir | payload                                        | handshake
//  in_ch   | in  | cmd, data_in                                   | valid/ready
//  out_ch  | out | status, data_out, front_word, rear_word,       | valid/ready
//          |     | occupancy, is_full, is_empty                   |
//  cfg_ch  | in  | capacity_in_use (flushes the buffer)           | valid/ready, always ready
//
// One request per cycle sustained while the output drains; the cell row is updated at the accepting edge.
// The result is registered in turn after acceptance: a pending stage holds status and
// the removed word, the output register then samples the front, rear and count.
// Reset empties all cells and sets capacity to 16; storage words are not cleared.
// A stalled output holds the pending stage, after which the input stalls as well.
module ring_buffer_deque_core (
  input  logic              clk,
  input  logic              rst_n,
  rbd_in_if.sink            in_ch,
  rbd_out_if.source         out_ch,
  rbd_cfg_if.sink           cfg_ch
);

  localparam int DEPTH = rbd_pkg::DEPTH;
  localparam int IDX_W = $clog2(DEPTH);

  logic [rbd_pkg::CAP_W-1:0] cap_r, cap_nxt;
  logic [rbd_pkg::CNT_W-1:0] count_r, count_nxt;

  rbd_pkg::cell_ctrl_t ctrl;
  rbd_pkg::status_t    st;
  logic signed [rbd_pkg::WORD_W-1:0] dout;

  logic [DEPTH-1:0]                  cell_v;
  logic signed [rbd_pkg::WORD_W-1:0] cell_d [DEPTH];
  logic [DEPTH-1:0]                  cell_rear;
  logic signed [rbd_pkg::WORD_W-1:0] rear_word;
  logic signed [rbd_pkg::WORD_W-1:0] front_word;

  logic                              pend_r, pend_nxt;
  rbd_pkg::status_t                  pend_status_r;
  logic signed [rbd_pkg::WORD_W-1:0] pend_dout_r;

  logic                              out_valid_r, out_valid_nxt;
  rbd_pkg::status_t                  out_status_r;
  logic signed [rbd_pkg::WORD_W-1:0] out_dout_r, out_front_r, out_rear_r;
  logic [rbd_pkg::CNT_W-1:0]         out_occ_r;
  logic                              out_full_r, out_empty_r;

  logic acc, cfg_acc, out_free, pend_move;

  assign cfg_ch.ready = 1'b1;
  assign cfg_acc      = cfg_ch.valid;
  assign out_free     = ~out_valid_r | out_ch.ready;
  assign pend_move    = pend_r & out_free;
  assign in_ch.ready  = ~pend_r | out_free;
  assign acc          = in_ch.valid & in_ch.ready;

  // effective capacity: zero acts as one, above the depth acts as the depth
  always_comb begin
    cap_nxt = cap_r;
    if (cfg_acc) begin
      if (cfg_ch.capacity_in_use == '0) begin
        cap_nxt = rbd_pkg::CAP_W'(1);
      end else if (cfg_ch.capacity_in_use > rbd_pkg::CAP_W'(DEPTH)) begin
        cap_nxt = rbd_pkg::CAP_W'(DEPTH);
      end else begin
        cap_nxt = cfg_ch.capacity_in_use;
      end
    end
  end

  always_comb begin
    ctrl      = '0;
    st        = rbd_pkg::ST_DONE;
    dout      = '0;
    count_nxt = count_r;
    if (cfg_acc) begin
      ctrl.flush = 1'b1;
      count_nxt  = '0;
    end else if (acc) begin
      unique case (rbd_pkg::cmd_t'(in_ch.cmd))
        rbd_pkg::CMD_ENQ: begin
          if (count_r >= cap_r) begin
            st = rbd_pkg::ST_FULL;
          end else begin
            ctrl.enq  = 1'b1;
            count_nxt = count_r + rbd_pkg::CNT_W'(1);
          end
        end
        rbd_pkg::CMD_DEQ_FRONT: begin
          if (count_r == '0) begin
            st = rbd_pkg::ST_EMPTY;
          end else begin
            ctrl.deq_front = 1'b1;
            dout           = front_word;
            count_nxt      = count_r - rbd_pkg::CNT_W'(1);
          end
        end
        rbd_pkg::CMD_DEQ_REAR: begin
          if (count_r == '0) begin
            st = rbd_pkg::ST_EMPTY;
          end else begin
            ctrl.deq_rear = 1'b1;
            dout          = rear_word;
            count_nxt     = count_r - rbd_pkg::CNT_W'(1);
          end
        end
        rbd_pkg::CMD_STATUS: begin
        end
        default: begin
        end
      endcase
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                              pv, nv;
    logic signed [rbd_pkg::WORD_W-1:0] nd;
    if (i == 0) begin : g_first
      assign pv = 1'b1;
    end else begin : g_mid
      assign pv = cell_v[i-1];
    end
    if (i == DEPTH-1) begin : g_last
      assign nv = 1'b0;
      assign nd = '0;
    end else begin : g_inner
      assign nv = cell_v[i+1];
      assign nd = cell_d[i+1];
    end
    rbd_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl       (ctrl),
      .data_in    (in_ch.data_in),
      .prev_valid (pv),
      .next_valid (nv),
      .next_data  (nd),
      .valid      (cell_v[i]),
      .data       (cell_d[i]),
      .is_rear    (cell_rear[i])
    );
  end

  assign front_word = cell_v[0] ? cell_d[0] : '0;

  // at most one cell flags itself as rear
  always_comb begin
    rear_word = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rear_word = rear_word | (cell_rear[i] ? cell_d[i] : '0);
    end
  end

  assign pend_nxt      = acc | (pend_r & ~out_free);
  assign out_valid_nxt = pend_r | (out_valid_r & ~out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= rbd_pkg::CAP_W'(DEPTH);
      count_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cap_r       <= cap_nxt;
      count_r     <= count_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      pend_status_r <= st;
      pend_dout_r   <= dout;
    end
    // cells and count already show the state after the pending request
    if (pend_move) begin
      out_status_r <= pend_status_r;
      out_dout_r   <= pend_dout_r;
      out_front_r  <= front_word;
      out_rear_r   <= rear_word;
      out_occ_r    <= count_r;
      out_full_r   <= (count_r == cap_r);
      out_empty_r  <= (count_r == '0);
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.status     = out_status_r;
  assign out_ch.data_out   = out_dout_r;
  assign out_ch.front_word = out_front_r;
  assign out_ch.rear_word  = out_rear_r;
  assign out_ch.occupancy  = out_occ_r;
  assign out_ch.is_full    = out_full_r;
  assign out_ch.is_empty   = out_empty_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= cap_r)
    else $error("stored count above capacity");

  a_cells_match_count: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(cell_v) == 32'(count_r))
    else $error("occupied cells disagree with count");

  a_rear_unique: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(cell_rear) &&
    ((count_r == '0) || cell_rear[IDX_W'(count_r - rbd_pkg::CNT_W'(1))]))
    else $error("rear cell not at end of occupied run");

  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_empty_r == (out_occ_r == '0)))
    else $error("empty flag inconsistent with occupancy");

endmodule

/* verif/ring_buffer_deque_core_tb.sv */
// Self-checking testbench for the double-ended ring buffer core
`timescale 1ns / 100ps

module ring_buffer_deque_core_tb;

  localparam int DEPTH           = rbd_pkg::DEPTH;
  localparam int WORD_W          = rbd_pkg::WORD_W;
  localparam int CNT_W           = rbd_pkg::CNT_W;
  localparam int CAP_W           = rbd_pkg::CAP_W;
  localparam int IDX_W           = $clog2(DEPTH);
  localparam int DIR_N           = 28;
  localparam int PHASE_N         = 9;
  localparam int ITEMS_PER_PHASE = 80;
  localparam int BACKLOG_ITEMS   = 50;
  localparam int HOLD_CYCLES     = 40;
  localparam int STALL_LIMIT     = 2000;

  typedef logic signed [WORD_W-1:0] word_t;

  typedef struct packed {
    rbd_pkg::status_t   status;
    word_t              taken;
    word_t              front;
    word_t              rear;
    logic [CNT_W-1:0]   fill;
    logic               full;
    logic               empty;
  } deque_view_t;

  typedef enum logic {ROW_REQ, ROW_CAP} row_kind_t;

  typedef struct {
    row_kind_t          kind;
    rbd_pkg::cmd_t      op;
    word_t              word;
    bit                 fixed;
    deque_view_t        want;
    logic [CAP_W-1:0]   cap;
  } stim_row_t;

  logic clk;
  logic rst_n;

  rbd_in_if  req_ch ();
  rbd_out_if res_ch ();
  rbd_cfg_if cap_ch ();

  ring_buffer_deque_core i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (req_ch),
    .out_ch (res_ch),
    .cfg_ch (cap_ch)
  );

  // shadow of the buffer
  word_t             ring_words [DEPTH];
  logic [IDX_W-1:0]  ring_head;
  logic [IDX_W-1:0]  ring_tail;
  logic [CNT_W-1:0]  ring_fill;
  logic [CAP_W-1:0]  cap_reg;

  deque_view_t       owed_views [$];
  stim_row_t         dir_rows [DIR_N];
  logic [CAP_W-1:0]  phase_caps [PHASE_N];
  int                mismatch_count;
  int                quiet_cycles;
  bit                backlog_hold;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [CAP_W-1:0] live_cap();
    if (cap_reg == '0) return CAP_W'(1);
    if (cap_reg > DEPTH) return CAP_W'(DEPTH);
    return cap_reg;
  endfunction

  function automatic void ring_flush();
    ring_head = '0;
    ring_tail = IDX_W'(live_cap() - 1'b1);
    ring_fill = '0;
  endfunction

  function automatic deque_view_t deque_apply(input rbd_pkg::cmd_t op, input word_t word);
    deque_view_t      v;
    logic [CAP_W-1:0] cap;
    cap      = live_cap();
    v        = '0;
    v.status = rbd_pkg::ST_DONE;
    case (op)
      rbd_pkg::CMD_ENQ: begin
        if (ring_fill >= cap) begin
          v.status = rbd_pkg::ST_FULL;
        end else begin
          ring_tail = ({1'b0, ring_tail} + 1'b1 >= cap) ? '0 : ring_tail + 1'b1;
          ring_words[ring_tail] = word;
          ring_fill = ring_fill + 1'b1;
        end
      end
      rbd_pkg::CMD_DEQ_FRONT: begin
        if (ring_fill == '0) begin
          v.status = rbd_pkg::ST_EMPTY;
        end else begin
          v.taken   = ring_words[ring_head];
          ring_head = ({1'b0, ring_head} + 1'b1 >= cap) ? '0 : ring_head + 1'b1;
          ring_fill = ring_fill - 1'b1;
        end
      end
      rbd_pkg::CMD_DEQ_REAR: begin
        if (ring_fill == '0) begin
          v.status = rbd_pkg::ST_EMPTY;
        end else begin
          v.taken   = ring_words[ring_tail];
          ring_tail = (ring_tail == '0) ? IDX_W'(cap - 1'b1) : ring_tail - 1'b1;
          ring_fill = ring_fill - 1'b1;
        end
      end
      default: ;
    endcase
    v.fill  = ring_fill;
    v.empty = (ring_fill == '0);
    v.full  = (ring_fill == cap);
    if (!v.empty) begin
      v.front = ring_words[ring_head];
      v.rear  = ring_words[ring_tail];
    end
    return v;
  endfunction

  function automatic stim_row_t row_pred(input rbd_pkg::cmd_t op, input word_t word);
    stim_row_t r;
    r.kind  = ROW_REQ;
    r.op    = op;
    r.word  = word;
    r.fixed = 1'b0;
    r.want  = '0;
    r.cap   = '0;
    return r;
  endfunction

  function automatic stim_row_t row_lit(input rbd_pkg::cmd_t op, input word_t word,
                                        input rbd_pkg::status_t st,
                                        input word_t taken, input word_t front,
                                        input word_t rear, input logic [CNT_W-1:0] fill,
                                        input logic full, input logic empty);
    stim_row_t r;
    r       = row_pred(op, word);
    r.fixed = 1'b1;
    r.want  = '{status: st, taken: taken, front: front, rear: rear, fill: fill,
                full: full, empty: empty};
    return r;
  endfunction

  function automatic stim_row_t row_cap(input logic [CAP_W-1:0] cap);
    stim_row_t r;
    r      = row_pred(rbd_pkg::CMD_STATUS, '0);
    r.kind = ROW_CAP;
    r.cap  = cap;
    return r;
  endfunction

  function automatic rbd_pkg::cmd_t pick_cmd(input int unsigned enq_weight);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < enq_weight) return rbd_pkg::CMD_ENQ;
    r = $urandom_range(0, 9);
    if (r == 0) return rbd_pkg::CMD_STATUS;
    return (r < 5) ? rbd_pkg::CMD_DEQ_FRONT : rbd_pkg::CMD_DEQ_REAR;
  endfunction

  function automatic word_t pick_word();
    case ($urandom_range(0, 11))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7FFF_FFFF;
      2:       return '0;
      3:       return -32'sd1;
      default: return word_t'($urandom);
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    $display("ERROR %0t: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic check_view(input deque_view_t want);
    if (res_ch.status !== want.status)
      report_mismatch($sformatf("status got %0h want %0h", res_ch.status, want.status));
    if (res_ch.data_out !== want.taken)
      report_mismatch($sformatf("data_out got %0h want %0h", res_ch.data_out, want.taken));
    if (res_ch.front_word !== want.front)
      report_mismatch($sformatf("front_word got %0h want %0h", res_ch.front_word, want.front));
    if (res_ch.rear_word !== want.rear)
      report_mismatch($sformatf("rear_word got %0h want %0h", res_ch.rear_word, want.rear));
    if (res_ch.occupancy !== want.fill)
      report_mismatch($sformatf("occupancy got %0d want %0d", res_ch.occupancy, want.fill));
    if (res_ch.is_full !== want.full)
      report_mismatch($sformatf("is_full got %b want %b", res_ch.is_full, want.full));
    if (res_ch.is_empty !== want.empty)
      report_mismatch($sformatf("is_empty got %b want %b", res_ch.is_empty, want.empty));
  endtask

  // request stays offered until taken; the expectation is formed at that edge
  task automatic send_req(input rbd_pkg::cmd_t op, input word_t word, input bit fixed,
                          input deque_view_t fixed_view);
    deque_view_t v;
    req_ch.valid   <= 1'b1;
    req_ch.cmd     <= op;
    req_ch.data_in <= word;
    do @(posedge clk); while (!req_ch.ready);
    v = deque_apply(op, word);
    owed_views.push_back(fixed ? fixed_view : v);
  endtask

  task automatic pause_sender(input int unsigned cycles);
    req_ch.valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic drain_results();
    req_ch.valid <= 1'b0;
    while (owed_views.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_cap(input logic [CAP_W-1:0] cap);
    cap_ch.valid           <= 1'b1;
    cap_ch.capacity_in_use <= cap;
    do @(posedge clk); while (!cap_ch.ready);
    cap_ch.valid <= 1'b0;
    cap_reg = cap;
    ring_flush();
  endtask

  task automatic run_phase(input int unsigned n_items);
    int unsigned sent;
    int unsigned burst;
    int unsigned enq_weight;
    sent = 0;
    while (sent < n_items) begin
      burst = $urandom_range(1, 24);
      case ($urandom_range(0, 2))
        0:       enq_weight = 25;
        1:       enq_weight = 50;
        default: enq_weight = 75;
      endcase
      repeat (burst) send_req(pick_cmd(enq_weight), pick_word(), 1'b0, '0);
      sent += burst;
      if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 12));
    end
  endtask

  // back-to-back requests against a held-off receiver, then wait for all results
  task automatic push_backlog();
    backlog_hold = 1'b1;
    repeat (BACKLOG_ITEMS) send_req(pick_cmd(60), pick_word(), 1'b0, '0);
    drain_results();
  endtask

  // result side: stall modes change every stretch, plus the long hold-off on request
  initial begin : result_sink
    int unsigned hold_left;
    int unsigned mode;
    int unsigned mode_left;
    int unsigned tick;
    hold_left    = 0;
    mode         = 0;
    mode_left    = 0;
    tick         = 0;
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      tick++;
      if (hold_left != 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else if (backlog_hold) begin
        backlog_hold = 1'b0;
        hold_left    = HOLD_CYCLES;
        res_ch.ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 3);
          mode_left = $urandom_range(20, 120);
        end
        mode_left--;
        case (mode)
          0:       res_ch.ready <= 1'b1;
          1:       res_ch.ready <= ($urandom_range(0, 3) != 0);
          2:       res_ch.ready <= (tick % 3 != 0);
          default: res_ch.ready <= $urandom_range(0, 1);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && res_ch.valid && res_ch.ready) begin
      if (owed_views.size() == 0) report_mismatch("result with no request outstanding");
      else check_view(owed_views.pop_front());
    end
  end

  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready) ||
        (cap_ch.valid && cap_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    rst_n                  <= 1'b0;
    req_ch.valid           <= 1'b0;
    req_ch.cmd             <= rbd_pkg::CMD_STATUS;
    req_ch.data_in         <= '0;
    cap_ch.valid           <= 1'b0;
    cap_ch.capacity_in_use <= '0;
    mismatch_count = 0;
    quiet_cycles   = 0;
    backlog_hold   = 1'b0;
    foreach (ring_words[i]) ring_words[i] = '0;
    cap_reg = CAP_W'(16);
    ring_flush();

    dir_rows = '{
      row_lit (rbd_pkg::CMD_STATUS, '0, rbd_pkg::ST_DONE, '0, '0, '0,
               5'd0, 1'b0, 1'b1),
      row_lit (rbd_pkg::CMD_DEQ_FRONT, '0, rbd_pkg::ST_EMPTY, '0, '0, '0,
               5'd0, 1'b0, 1'b1),
      row_lit (rbd_pkg::CMD_DEQ_REAR, '0, rbd_pkg::ST_EMPTY, '0, '0, '0,
               5'd0, 1'b0, 1'b1),
      row_lit (rbd_pkg::CMD_ENQ, 32'sh8000_0000, rbd_pkg::ST_DONE, '0,
               32'sh8000_0000, 32'sh8000_0000, 5'd1, 1'b0, 1'b0),
      row_pred(rbd_pkg::CMD_ENQ,       32'sh7FFF_FFFF),
      row_pred(rbd_pkg::CMD_ENQ,       -32'sd1),
      row_pred(rbd_pkg::CMD_ENQ,       '0),
      row_pred(rbd_pkg::CMD_DEQ_REAR,  '0),
      row_pred(rbd_pkg::CMD_DEQ_FRONT, '0),
      row_pred(rbd_pkg::CMD_STATUS,    -32'sd1),
      // zero capacity behaves as one entry
      row_cap (5'd0),
      row_lit (rbd_pkg::CMD_STATUS, '0, rbd_pkg::ST_DONE, '0, '0, '0,
               5'd0, 1'b0, 1'b1),
      row_lit (rbd_pkg::CMD_ENQ, 32'sh5555_AAAA, rbd_pkg::ST_DONE, '0,
               32'sh5555_AAAA, 32'sh5555_AAAA, 5'd1, 1'b1, 1'b0),
      row_lit (rbd_pkg::CMD_ENQ, 32'sh1234_5678, rbd_pkg::ST_FULL, '0,
               32'sh5555_AAAA, 32'sh5555_AAAA, 5'd1, 1'b1, 1'b0),
      row_pred(rbd_pkg::CMD_DEQ_FRONT, '0),
      row_pred(rbd_pkg::CMD_ENQ,       32'shAAAA_5555),
      row_pred(rbd_pkg::CMD_DEQ_REAR,  '0),
      row_lit (rbd_pkg::CMD_DEQ_REAR, '0, rbd_pkg::ST_EMPTY, '0, '0, '0,
               5'd0, 1'b0, 1'b1),
      // two entries: fill, reject, wrap both indices
      row_cap (5'd2),
      row_pred(rbd_pkg::CMD_ENQ,       32'sh0000_0001),
      row_pred(rbd_pkg::CMD_ENQ,       32'sh8000_0001),
      row_pred(rbd_pkg::CMD_ENQ,       32'shDEAD_BEEF),
      row_pred(rbd_pkg::CMD_DEQ_FRONT, '0),
      row_pred(rbd_pkg::CMD_ENQ,       32'sh0F0F_0F0F),
      row_pred(rbd_pkg::CMD_DEQ_REAR,  '0),
      row_pred(rbd_pkg::CMD_DEQ_FRONT, '0),
      // above depth clamps to depth
      row_cap (5'd31),
      row_pred(rbd_pkg::CMD_ENQ,       32'sh7FFF_FFFF)
    };

    phase_caps = '{5'd5, 5'd1, 5'd16, 5'd0, 5'd31, 5'd2, 5'd9, 5'd17, 5'd3};
    phase_caps[PHASE_N-1] = CAP_W'($urandom_range(0, 31));

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CAP) begin
        drain_results();
        write_cap(dir_rows[i].cap);
      end else begin
        send_req(dir_rows[i].op, dir_rows[i].word, dir_rows[i].fixed, dir_rows[i].want);
        if ($urandom_range(0, 2) == 0) pause_sender($urandom_range(1, 4));
      end
    end

    foreach (phase_caps[p]) begin
      drain_results();
      write_cap(phase_caps[p]);
      if (p == 2 || p == 6) push_backlog();
      run_phase(ITEMS_PER_PHASE);
    end

    drain_results();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

/* filelist.f */
src/rbd_pkg.sv
src/rbd_ifs.sv
src/rbd_cell.sv
src/ring_buffer_deque_core.sv
verif/ring_buffer_deque_core_tb.sv
